@@ sv/dgr_pkg.sv @@
// Shared types, character codes and the glyph font of the digit glyph renderer.
`timescale 1ns / 1ps

package dgr_pkg;

    // Configuration register indexes
    typedef enum logic [0:0] {
        CFG_TEX_WIDTH  = 1'b0,
        CFG_TEX_HEIGHT = 1'b1
    } t_cfg_idx;

    localparam int unsigned CFG_DATA_W = 11;
    localparam int unsigned COORD_W    = 13;
    localparam int unsigned PIX_W      = 10;
    localparam int unsigned GLYPH_W    = 4;

    localparam logic [10:0] TEX_RESET = 11'd512;
    localparam logic [10:0] TEX_CAP   = 11'd2047;

    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_DOT   = 8'h2E;
    localparam logic [7:0] CHAR_COMMA = 8'h2C;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;

    localparam logic [GLYPH_W-1:0] GLYPH_SEP   = 4'd10;
    localparam logic [GLYPH_W-1:0] GLYPH_MINUS = 4'd11;

    // Doubled scan: 10 rows by 6 columns
    localparam logic [3:0] LAST_ROW = 4'd9;
    localparam logic [2:0] LAST_COL = 3'd5;

    typedef enum logic [1:0] {
        BACK_IDLE,
        BACK_SCAN,
        BACK_FLUSH
    } t_back_state;

    // One font row: bit 2 is the leftmost cell
    function automatic logic [2:0] glyph_row(input logic [GLYPH_W-1:0] g,
                                             input logic [2:0] r);
        logic [14:0] rows;
        logic [2:0]  sel;
        unique case (g)
            4'd0:    rows = {3'd2, 3'd5, 3'd5, 3'd5, 3'd2};
            4'd1:    rows = {3'd2, 3'd6, 3'd2, 3'd2, 3'd7};
            4'd2:    rows = {3'd6, 3'd1, 3'd1, 3'd2, 3'd7};
            4'd3:    rows = {3'd6, 3'd1, 3'd2, 3'd1, 3'd6};
            4'd4:    rows = {3'd5, 3'd5, 3'd7, 3'd1, 3'd1};
            4'd5:    rows = {3'd7, 3'd4, 3'd6, 3'd1, 3'd6};
            4'd6:    rows = {3'd2, 3'd4, 3'd6, 3'd5, 3'd2};
            4'd7:    rows = {3'd7, 3'd1, 3'd1, 3'd2, 3'd2};
            4'd8:    rows = {3'd2, 3'd5, 3'd2, 3'd5, 3'd2};
            4'd9:    rows = {3'd2, 3'd5, 3'd3, 3'd1, 3'd2};
            4'd10:   rows = {3'd0, 3'd0, 3'd0, 3'd0, 3'd1};
            4'd11:   rows = {3'd0, 3'd0, 3'd7, 3'd0, 3'd0};
            default: rows = 15'd0;
        endcase
        unique case (r)
            3'd0:    sel = rows[14:12];
            3'd1:    sel = rows[11:9];
            3'd2:    sel = rows[8:6];
            3'd3:    sel = rows[5:3];
            3'd4:    sel = rows[2:0];
            default: sel = 3'd0;
        endcase
        return sel;
    endfunction

endpackage

@@ sv/digit_glyph_renderer_top.sv @@
// Top level of the digit glyph renderer: configuration, front, queue and back.
`timescale 1ns / 1ps

// Digit glyph renderer: draws one character of a number string per request.
// Input channel (i_in_valid / o_in_stall): a character code, the string base
// position and a new-string flag. Digits, '.', ',' and '-' become 3x5 glyphs
// doubled to 6x10 pixels; any other character only advances the position.
// Output channel (o_out_valid / i_out_stall): one request per white pixel
// inside the texture, o_last_pixel set on the last one of a character.
// A character that draws nothing produces no output request at all.
// The back end scans one doubled cell per cycle while the output does not
// hold it; each drawn character is loaded, scanned and flushed in turn,
// and other characters never reach the queue. The two-entry command queue
// lets the front keep taking characters while the back scans. While
// i_out_stall is high the output holds and the scan holds as soon as a
// second surviving pixel is pending; the queue then fills and o_in_stall
// rises. Reset (synchronous, i_rst_n low) empties queue and pipeline,
// clears the position and separator counters and sets both texture sizes
// to 512. Configuration writes (i_cfg_we) are taken in the same cycle; the
// user must write only while idle, as the block does not enforce it.

module digit_glyph_renderer_top #(
    parameter int MAX_DIM   = 1024,
    parameter int POS_LIMIT = 255
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [0:0]  i_cfg_idx,
    input  logic [10:0] i_cfg_wdata,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_char_code,
    input  logic [12:0] i_base_x,
    input  logic [12:0] i_base_y,
    input  logic        i_new_string,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [9:0]  o_pix_x,
    output logic [9:0]  o_pix_y,
    output logic        o_last_pixel
);

    // Counter width follows the saturation limit
    localparam int CW    = $clog2(POS_LIMIT + 1);
    // Column origin: base + 8/position - 4/separator, headroom for sign and sums
    localparam int XW    = ((CW + 3 > 12) ? CW + 3 : 12) + 2;
    localparam int CMD_W = dgr_pkg::GLYPH_W + XW + dgr_pkg::COORD_W;
    // Effective limit never exceeds what the 11-bit register can hold
    localparam logic [10:0] DIM_CAP =
        (MAX_DIM < 2047) ? 11'(MAX_DIM) : dgr_pkg::TEX_CAP;
    localparam logic [10:0] SIZE_RESET =
        (dgr_pkg::TEX_RESET < DIM_CAP) ? dgr_pkg::TEX_RESET : DIM_CAP;

    // Store the clamped texture size directly at write time
    logic [10:0] r_width, r_height;
    logic [10:0] cfg_clamped;

    assign cfg_clamped = (i_cfg_wdata < DIM_CAP) ? i_cfg_wdata : DIM_CAP;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= SIZE_RESET;
            r_height <= SIZE_RESET;
        end else if (i_cfg_we) begin
            unique case (dgr_pkg::t_cfg_idx'(i_cfg_idx))
                dgr_pkg::CFG_TEX_WIDTH:  r_width  <= cfg_clamped;
                dgr_pkg::CFG_TEX_HEIGHT: r_height <= cfg_clamped;
                default:                 r_width  <= r_width;
            endcase
        end
    end

    logic             q_full, q_valid, q_pop, push, in_accept;
    logic [CMD_W-1:0] push_cmd, q_cmd;

    // Stall input whenever the queue has no room for a command
    assign o_in_stall = q_full;
    assign in_accept  = i_in_valid && !q_full;

    dgr_front #(
        .POS_LIMIT (POS_LIMIT),
        .CW        (CW),
        .XW        (XW),
        .CMD_W     (CMD_W)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (in_accept),
        .i_char_code  (i_char_code),
        .i_base_x     (i_base_x),
        .i_base_y     (i_base_y),
        .i_new_string (i_new_string),
        .o_push       (push),
        .o_cmd        (push_cmd)
    );

    dgr_queue #(
        .W (CMD_W)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_cmd),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_data  (q_cmd)
    );

    dgr_back #(
        .XW    (XW),
        .CMD_W (CMD_W)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd_valid  (q_valid),
        .i_cmd        (q_cmd),
        .o_cmd_pop    (q_pop),
        .i_width      (r_width),
        .i_height     (r_height),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_pix_x      (o_pix_x),
        .o_pix_y      (o_pix_y),
        .o_last_pixel (o_last_pixel)
    );

endmodule

@@ sv/dgr_queue.sv @@
// Two-entry command queue between the classifying front and the scanning back.
`timescale 1ns / 1ps

module dgr_queue #(
    parameter int W = 40
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    output logic         o_full,
    input  logic         i_pop,
    output logic         o_valid,
    output logic [W-1:0] o_data
);

    logic [W-1:0] r_mem [2];
    logic         r_wr_ptr, n_wr_ptr;
    logic         r_rd_ptr, n_rd_ptr;
    logic [1:0]   r_count, n_count;

    logic do_push, do_pop;

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_data  = r_mem[r_rd_ptr];

    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wr_ptr = do_push ? ~r_wr_ptr : r_wr_ptr;
        n_rd_ptr = do_pop ? ~r_rd_ptr : r_rd_ptr;
        n_count  = r_count;
        if (do_push && !do_pop) begin
            n_count = r_count + 2'd1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

@@ sv/dgr_front.sv @@
// Front end: accept characters, keep the string counters, form glyph commands.
`timescale 1ns / 1ps

module dgr_front #(
    parameter int POS_LIMIT = 255,
    parameter int CW        = 8,
    parameter int XW        = 14,
    parameter int CMD_W     = 31
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic [7:0]        i_char_code,
    input  logic [12:0]       i_base_x,
    input  logic [12:0]       i_base_y,
    input  logic              i_new_string,
    output logic              o_push,
    output logic [CMD_W-1:0]  o_cmd
);

    localparam logic [CW-1:0] LIMIT = CW'(POS_LIMIT);

    logic [CW-1:0] r_pos, n_pos;
    logic [CW-1:0] r_sep, n_sep;

    logic [CW-1:0]          pos_cur, sep_cur;
    logic                   is_digit, is_sep, is_minus;
    logic [dgr_pkg::GLYPH_W-1:0] glyph;
    logic [7:0]             digit_off;
    logic signed [XW-1:0]   x0;

    always_comb begin
        pos_cur   = i_new_string ? '0 : r_pos;
        sep_cur   = i_new_string ? '0 : r_sep;
        digit_off = i_char_code - dgr_pkg::CHAR_ZERO;
        is_digit  = (i_char_code >= dgr_pkg::CHAR_ZERO) && (i_char_code <= dgr_pkg::CHAR_NINE);
        is_sep    = (i_char_code == dgr_pkg::CHAR_DOT) || (i_char_code == dgr_pkg::CHAR_COMMA);
        is_minus  = (i_char_code == dgr_pkg::CHAR_MINUS);

        // Separator counts itself before it is placed
        if (is_sep && sep_cur < LIMIT) begin
            sep_cur = sep_cur + CW'(1);
        end

        priority if (is_digit) begin
            glyph = digit_off[dgr_pkg::GLYPH_W-1:0];
        end else if (is_sep) begin
            glyph = dgr_pkg::GLYPH_SEP;
        end else begin
            glyph = dgr_pkg::GLYPH_MINUS;
        end

        x0 = $signed({{(XW-13){i_base_x[12]}}, i_base_x})
           + $signed({{(XW-CW-3){1'b0}}, pos_cur, 3'b000})
           - $signed({{(XW-CW-2){1'b0}}, sep_cur, 2'b00});

        n_pos = (pos_cur < LIMIT) ? pos_cur + CW'(1) : LIMIT;
        n_sep = sep_cur;
    end

    assign o_push = i_accept && (is_digit || is_sep || is_minus);
    assign o_cmd  = {glyph, x0, i_base_y};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
            r_sep <= '0;
        end else if (i_accept) begin
            r_pos <= n_pos;
            r_sep <= n_sep;
        end
    end

endmodule

@@ sv/dgr_back.sv @@
// Back end: scan the doubled glyph, clip to the texture and emit pixels.
`timescale 1ns / 1ps

module dgr_back #(
    parameter int XW    = 14,
    parameter int CMD_W = 31
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cmd_valid,
    input  logic [CMD_W-1:0] i_cmd,
    output logic             o_cmd_pop,
    input  logic [10:0]      i_width,
    input  logic [10:0]      i_height,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output logic [9:0]       o_pix_x,
    output logic [9:0]       o_pix_y,
    output logic             o_last_pixel
);

    localparam int YW = 14;

    dgr_pkg::t_back_state r_state, n_state;

    logic [dgr_pkg::GLYPH_W-1:0] r_glyph;
    logic signed [XW-1:0]        r_x0;
    logic [12:0]                 r_by;
    logic [3:0]                  r_row, n_row;
    logic [2:0]                  r_col, n_col;

    logic       r_pend_valid, n_pend_valid;
    logic [9:0] r_pend_x, r_pend_y;

    logic       r_out_valid, n_out_valid;
    logic [9:0] r_out_x, r_out_y;
    logic       r_out_last;

    logic                 out_free, out_load, out_last, pend_load, cmd_load;
    logic [2:0]           bits;
    logic                 cell_on, survive;
    logic signed [XW-1:0] px;
    logic signed [YW-1:0] py;

    assign out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        bits = dgr_pkg::glyph_row(r_glyph, r_row[3:1]);
        unique case (r_col[2:1])
            2'd0:    cell_on = bits[2];
            2'd1:    cell_on = bits[1];
            default: cell_on = bits[0];
        endcase
        px = r_x0 + $signed({{(XW-3){1'b0}}, r_col});
        py = $signed({r_by[12], r_by}) - $signed({{(YW-4){1'b0}}, r_row});
        survive = cell_on
               && !px[XW-1] && ($unsigned(px) < {{(XW-11){1'b0}}, i_width})
               && !py[YW-1] && ($unsigned(py) < {{(YW-11){1'b0}}, i_height});
    end

    always_comb begin
        n_state      = r_state;
        n_row        = r_row;
        n_col        = r_col;
        n_pend_valid = r_pend_valid;
        out_load     = 1'b0;
        out_last     = 1'b0;
        pend_load    = 1'b0;
        cmd_load     = 1'b0;
        o_cmd_pop    = 1'b0;
        unique case (r_state)
            dgr_pkg::BACK_IDLE: begin
                if (i_cmd_valid) begin
                    o_cmd_pop = 1'b1;
                    cmd_load  = 1'b1;
                    n_row     = 4'd0;
                    n_col     = 3'd0;
                    n_state   = dgr_pkg::BACK_SCAN;
                end
            end
            dgr_pkg::BACK_SCAN: begin
                // Hold the scan while a new pixel would need the busy output
                if (!(survive && r_pend_valid && !out_free)) begin
                    if (survive) begin
                        pend_load    = 1'b1;
                        n_pend_valid = 1'b1;
                        out_load     = r_pend_valid;
                    end
                    if (r_col == dgr_pkg::LAST_COL) begin
                        n_col = 3'd0;
                        if (r_row == dgr_pkg::LAST_ROW) begin
                            n_state = dgr_pkg::BACK_FLUSH;
                        end else begin
                            n_row = r_row + 4'd1;
                        end
                    end else begin
                        n_col = r_col + 3'd1;
                    end
                end
            end
            dgr_pkg::BACK_FLUSH: begin
                if (!r_pend_valid) begin
                    n_state = dgr_pkg::BACK_IDLE;
                end else if (out_free) begin
                    out_load     = 1'b1;
                    out_last     = 1'b1;
                    n_pend_valid = 1'b0;
                    n_state      = dgr_pkg::BACK_IDLE;
                end
            end
            default: n_state = dgr_pkg::BACK_IDLE;
        endcase
        n_out_valid = out_load ? 1'b1 : (out_free ? 1'b0 : r_out_valid);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= dgr_pkg::BACK_IDLE;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_pend_valid <= n_pend_valid;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_row <= n_row;
        r_col <= n_col;
        if (cmd_load) begin
            r_glyph <= i_cmd[CMD_W-1 -: dgr_pkg::GLYPH_W];
            r_x0    <= $signed(i_cmd[XW+12:13]);
            r_by    <= i_cmd[12:0];
        end
        if (out_load) begin
            r_out_x    <= r_pend_x;
            r_out_y    <= r_pend_y;
            r_out_last <= out_last;
        end
        if (pend_load) begin
            r_pend_x <= px[9:0];
            r_pend_y <= py[9:0];
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_pix_x      = r_out_x;
    assign o_pix_y      = r_out_y;
    assign o_last_pixel = r_out_last;

endmodule
